// ===== hdl/ustlc_pkg.sv =====
`default_nettype none

package ustlc_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;
    localparam int HEIGHT_W   = 10;
    localparam int SETTLE_W   = 8;
    localparam int TRIG_W     = 8;
    localparam int HOLDOFF_W  = 20;
    localparam int PHASE_CNT_W = 20;

    localparam int WIDTH_OUT_W = 16;
    localparam int DIST_OUT_W  = 17;
    localparam int PCT_OUT_W   = 15;
    localparam int HCM_W       = 17;
    localparam int PCT_Q_W     = 14;
    localparam int DEN_W       = 10;

    localparam logic [CFG_IDX_W-1:0] REG_TANK_HEIGHT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_LOW  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_WIDTH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF     = 8'd3;

    localparam logic [HEIGHT_W-1:0]  RST_TANK_HEIGHT = 10'd100;
    localparam logic [SETTLE_W-1:0]  RST_SETTLE_LOW  = 8'd2;
    localparam logic [TRIG_W-1:0]    RST_TRIG_WIDTH  = 8'd10;
    localparam logic [HOLDOFF_W-1:0] RST_HOLDOFF     = 20'd300000;

    localparam int DIST_MUL  = 172;
    localparam int DIST_DIV  = 100;
    localparam int PCT_SCALE = 100;

    localparam logic [PCT_Q_W-1:0] Q_QUARTER_LO = 14'd2300;
    localparam logic [PCT_Q_W-1:0] Q_QUARTER_HI = 14'd2700;
    localparam logic [PCT_Q_W-1:0] Q_HALF_LO    = 14'd4800;
    localparam logic [PCT_Q_W-1:0] Q_HALF_HI    = 14'd5200;
    localparam logic [PCT_Q_W-1:0] Q_THREE_Q_LO = 14'd7300;
    localparam logic [PCT_Q_W-1:0] Q_THREE_Q_HI = 14'd7700;
    localparam logic [PCT_Q_W-1:0] Q_FULL       = 14'd9700;
    localparam logic [PCT_Q_W-1:0] Q_URGENT     = 14'd500;

    localparam logic signed [PCT_OUT_W-1:0] PCT_FLOOR = -15'sd10000;

    typedef enum logic [2:0] {
        PH_SETTLE,
        PH_PULSE,
        PH_WAIT,
        PH_MEASURE,
        PH_HOLDOFF
    } t_phase;

    typedef enum logic [2:0] {
        C_IDLE,
        C_DIV_D,
        C_SUB,
        C_CHK,
        C_DIV_P,
        C_HOLD
    } t_calc_state;

    typedef enum logic [2:0] {
        BAND_NONE,
        BAND_QUARTER,
        BAND_HALF,
        BAND_THREE_Q,
        BAND_FULL,
        BAND_URGENT,
        BAND_ERROR
    } t_band;

    typedef struct packed {
        logic trig;
        logic done;
    } t_tick;

    typedef struct packed {
        logic [WIDTH_OUT_W-1:0]      width;
        logic [DIST_OUT_W-1:0]       dist_hcm;
        logic signed [PCT_OUT_W-1:0] pct;
        t_band                       band;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/ustlc_div.sv =====
`default_nettype none

module ustlc_div
    import ustlc_pkg::*;
#(
    parameter int NUM_W = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot,
    output logic [DEN_W-1:0]      o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [DEN_W:0] w_trial;
    logic [DEN_W:0] w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== hdl/ustlc_tick.sv =====
`default_nettype none

module ustlc_tick
    import ustlc_pkg::*;
#(
    parameter int ECHO_W = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic                 i_echo,
    input  wire logic [SETTLE_W-1:0]  i_settle,
    input  wire logic [TRIG_W-1:0]    i_trig_width,
    input  wire logic [HOLDOFF_W-1:0] i_holdoff,
    output t_tick                     o_tick,
    output logic [ECHO_W-1:0]         o_width
);

    t_phase                 r_phase, n_phase;
    logic [PHASE_CNT_W-1:0] r_phase_ticks, n_phase_ticks;
    logic [ECHO_W-1:0]      r_echo_ticks, n_echo_ticks;

    t_phase                 w_ph;
    logic [PHASE_CNT_W-1:0] w_pt;
    logic [TRIG_W-1:0]      w_tw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SETTLE;
            r_phase_ticks <= '0;
            r_echo_ticks  <= '0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_phase_ticks <= n_phase_ticks;
            r_echo_ticks  <= n_echo_ticks;
        end
    end

    always_comb begin
        w_tw = (i_trig_width == '0) ? TRIG_W'(1) : i_trig_width;
        w_ph = r_phase;
        w_pt = r_phase_ticks;
        o_tick = '0;
        if (w_ph == PH_HOLDOFF && w_pt >= PHASE_CNT_W'(i_holdoff)) begin
            w_ph = PH_SETTLE;
            w_pt = '0;
        end
        if (w_ph == PH_SETTLE && w_pt >= PHASE_CNT_W'(i_settle)) begin
            w_ph = PH_PULSE;
            w_pt = '0;
        end
        n_phase       = w_ph;
        n_phase_ticks = w_pt;
        n_echo_ticks  = r_echo_ticks;
        unique case (w_ph)
            PH_SETTLE: begin
                n_phase_ticks = w_pt + 1'b1;
            end
            PH_PULSE: begin
                o_tick.trig   = 1'b1;
                n_phase_ticks = w_pt + 1'b1;
                if (n_phase_ticks >= PHASE_CNT_W'(w_tw)) begin
                    n_phase       = PH_WAIT;
                    n_phase_ticks = '0;
                end
            end
            PH_WAIT: begin
                if (i_echo) begin
                    n_phase      = PH_MEASURE;
                    n_echo_ticks = ECHO_W'(1);
                end
            end
            PH_MEASURE: begin
                if (i_echo) begin
                    if (r_echo_ticks != '1) begin
                        n_echo_ticks = r_echo_ticks + 1'b1;
                    end
                end else begin
                    o_tick.done   = 1'b1;
                    n_phase       = PH_HOLDOFF;
                    n_phase_ticks = '0;
                    n_echo_ticks  = '0;
                end
            end
            PH_HOLDOFF: begin
                n_phase_ticks = w_pt + 1'b1;
            end
            default: begin
                n_phase       = PH_SETTLE;
                n_phase_ticks = '0;
            end
        endcase
    end

    assign o_width = r_echo_ticks;

endmodule

`default_nettype wire

// ===== hdl/ustlc_calc.sv =====
`default_nettype none

module ustlc_calc
    import ustlc_pkg::*;
#(
    parameter int ECHO_W = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [ECHO_W-1:0]   i_width,
    input  wire logic [HEIGHT_W-1:0] i_height,
    input  wire logic                i_out_free,
    output logic                     o_busy,
    output logic                     o_done,
    output t_result                  o_res
);

    localparam int DW      = ECHO_W + 1;
    localparam int DK      = ECHO_W + 7;
    localparam int RCP_W   = ECHO_W + 8;
    localparam int DPROD_W = ECHO_W + RCP_W;
    // distance = width * 172 / 100 through a rounded-up reciprocal, exact for every width
    localparam longint unsigned DIST_RCP =
        ((longint'(DIST_MUL) << DK) + longint'(DIST_DIV - 1)) / longint'(DIST_DIV);
    localparam int DIV_W   = 24;
    localparam int PW      = ((DW > HCM_W) ? DW : HCM_W) + 1;

    t_calc_state r_state, n_state;

    logic [ECHO_W-1:0]    r_width;
    logic [DW-1:0]        r_dist;
    logic signed [PW-1:0] r_p;
    logic                 r_neg;
    t_result              r_res;

    logic [HEIGHT_W-1:0] w_h;
    logic [HCM_W-1:0]    w_h100;
    logic [HCM_W-1:0]    w_mag;
    logic                w_sat;
    logic [DPROD_W-1:0]  w_dprod;

    logic             div_start;
    logic [DIV_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic [DEN_W-1:0] div_rem;

    logic [PCT_Q_W-1:0] w_q;
    logic               w_rnz;
    t_band              w_band;

    function automatic logic q_above(logic [PCT_Q_W-1:0] q, logic rnz,
                                     logic [PCT_Q_W-1:0] k);
        return (q > k) || (q == k && rnz);
    endfunction

    ustlc_div #(
        .NUM_W (DIV_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    assign w_h     = (i_height == '0) ? HEIGHT_W'(1) : i_height;
    assign w_h100  = HCM_W'(w_h) * HCM_W'(PCT_SCALE);
    assign w_mag   = HCM_W'(r_p[PW-1] ? -r_p : r_p);
    assign w_sat   = PW'(r_dist) >= PW'({w_h100, 1'b0});
    assign w_dprod = DPROD_W'(r_width) * DPROD_W'(DIST_RCP);
    assign w_q     = div_quot[PCT_Q_W-1:0];
    assign w_rnz   = (div_rem != '0);

    always_comb begin
        if (q_above(w_q, w_rnz, Q_QUARTER_LO) && w_q < Q_QUARTER_HI) begin
            w_band = BAND_QUARTER;
        end else if (q_above(w_q, w_rnz, Q_HALF_LO) && w_q < Q_HALF_HI) begin
            w_band = BAND_HALF;
        end else if (q_above(w_q, w_rnz, Q_THREE_Q_LO) && w_q < Q_THREE_Q_HI) begin
            w_band = BAND_THREE_Q;
        end else if (q_above(w_q, w_rnz, Q_FULL)) begin
            w_band = BAND_FULL;
        end else if (w_q < Q_URGENT) begin
            w_band = BAND_URGENT;
        end else begin
            w_band = BAND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = w_h;
        o_done    = 1'b0;
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    n_state = C_DIV_D;
                end
            end
            C_DIV_D: begin
                n_state = C_SUB;
            end
            C_SUB: begin
                n_state = C_CHK;
            end
            C_CHK: begin
                if (r_p[PW-1] && w_sat) begin
                    n_state = C_HOLD;
                end else begin
                    div_start = 1'b1;
                    div_num   = DIV_W'(24'(w_mag) * 24'(PCT_SCALE));
                    n_state   = C_DIV_P;
                end
            end
            C_DIV_P: begin
                if (div_done) begin
                    n_state = C_HOLD;
                end
            end
            C_HOLD: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = C_IDLE;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                r_width <= i_width;
            end
            C_DIV_D: begin
                r_dist <= w_dprod[DK +: DW];
            end
            C_SUB: begin
                r_p <= $signed(PW'(w_h100)) - $signed(PW'(r_dist));
                r_res.width    <= WIDTH_OUT_W'(r_width);
                r_res.dist_hcm <= DIST_OUT_W'(r_dist);
            end
            C_CHK: begin
                r_neg <= r_p[PW-1];
                if (r_p[PW-1] && w_sat) begin
                    r_res.pct  <= PCT_FLOOR;
                    r_res.band <= BAND_ERROR;
                end
            end
            C_DIV_P: begin
                if (div_done) begin
                    if (r_neg) begin
                        r_res.pct  <= -$signed(PCT_OUT_W'(w_q));
                        r_res.band <= BAND_ERROR;
                    end else begin
                        r_res.pct  <= $signed(PCT_OUT_W'(w_q));
                        r_res.band <= w_band;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_busy = (r_state != C_IDLE);
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ===== hdl/ultrasonic_tank_level_classifier_top.sv =====
// Ordinary tick: result registered in the cycle after the request is accepted.
// Measurement-end tick: distance, difference and saturation check in turn, then the
// percentage from one pass of the bit-serial divider (skipped when it saturates low).
// No request is taken while that sequence runs or while a result waits.
// Synchronous active-low reset: settle phase, counters zero, registers at defaults.
`default_nettype none

module ultrasonic_tank_level_classifier_top
    import ustlc_pkg::*;
#(
    parameter int ECHO_WIDTH_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_echo_level,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_trigger_level,
    output logic                       o_result_valid,
    output logic [WIDTH_OUT_W-1:0]     o_echo_width_us,
    output logic [DIST_OUT_W-1:0]      o_distance_hcm,
    output logic signed [PCT_OUT_W-1:0] o_percent_hundredths,
    output logic [2:0]                 o_level_band,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [HEIGHT_W-1:0]  r_tank_height;
    logic [SETTLE_W-1:0]  r_settle_low;
    logic [TRIG_W-1:0]    r_trig_width;
    logic [HOLDOFF_W-1:0] r_holdoff;

    logic                        r_out_valid;
    logic                        r_trig;
    logic                        r_res_valid;
    logic [WIDTH_OUT_W-1:0]      r_width;
    logic [DIST_OUT_W-1:0]       r_dist;
    logic signed [PCT_OUT_W-1:0] r_pct;
    logic [2:0]                  r_band;

    logic                       w_accept;
    logic                       w_out_free;
    t_tick                      w_tick;
    logic [ECHO_WIDTH_BITS-1:0] w_width;
    logic                       w_busy;
    logic                       w_done;
    t_result                    w_res;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = !w_busy && w_out_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tank_height <= RST_TANK_HEIGHT;
            r_settle_low  <= RST_SETTLE_LOW;
            r_trig_width  <= RST_TRIG_WIDTH;
            r_holdoff     <= RST_HOLDOFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TANK_HEIGHT: r_tank_height <= i_cfg_data[HEIGHT_W-1:0];
                REG_SETTLE_LOW:  r_settle_low  <= i_cfg_data[SETTLE_W-1:0];
                REG_TRIG_WIDTH:  r_trig_width  <= i_cfg_data[TRIG_W-1:0];
                REG_HOLDOFF:     r_holdoff     <= i_cfg_data[HOLDOFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ustlc_tick #(
        .ECHO_W (ECHO_WIDTH_BITS)
    ) u_tick (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_echo       (i_echo_level),
        .i_settle     (r_settle_low),
        .i_trig_width (r_trig_width),
        .i_holdoff    (r_holdoff),
        .o_tick       (w_tick),
        .o_width      (w_width)
    );

    ustlc_calc #(
        .ECHO_W (ECHO_WIDTH_BITS)
    ) u_calc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && w_tick.done),
        .i_width    (w_width),
        .i_height   (r_tank_height),
        .i_out_free (w_out_free),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_accept && !w_tick.done) || w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_tick.done) begin
            r_trig      <= w_tick.trig;
            r_res_valid <= 1'b0;
            r_width     <= '0;
            r_dist      <= '0;
            r_pct       <= '0;
            r_band      <= BAND_NONE;
        end else if (w_done) begin
            r_trig      <= 1'b0;
            r_res_valid <= 1'b1;
            r_width     <= w_res.width;
            r_dist      <= w_res.dist_hcm;
            r_pct       <= w_res.pct;
            r_band      <= w_res.band;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_trigger_level      = r_trig;
    assign o_result_valid       = r_res_valid;
    assign o_echo_width_us      = r_width;
    assign o_distance_hcm       = r_dist;
    assign o_percent_hundredths = r_pct;
    assign o_level_band         = r_band;

endmodule

`default_nettype wire

// ===== test/ultrasonic_tank_level_classifier_top_test.sv =====
`default_nettype none

module ultrasonic_tank_level_classifier_top_test;
    import ustlc_pkg::*;

    localparam int ECHO_BITS    = 16;
    localparam int unsigned ECHO_SAT = (1 << ECHO_BITS) - 1;
    localparam int DRAIN_CYCLES = 100;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic                   trig;
        logic                   done;
        logic [WIDTH_OUT_W-1:0] width;
        logic [DIST_OUT_W-1:0]  dist_hcm;
        logic [PCT_OUT_W-1:0]   pct;
        t_band                  band;
    } t_tick_exp;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_echo_level = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_trigger_level;
    logic                  o_result_valid;
    logic [WIDTH_OUT_W-1:0] o_echo_width_us;
    logic [DIST_OUT_W-1:0] o_distance_hcm;
    logic signed [PCT_OUT_W-1:0] o_percent_hundredths;
    logic [2:0]            o_level_band;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    ultrasonic_tank_level_classifier_top #(
        .ECHO_WIDTH_BITS(ECHO_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_echo_level(i_echo_level),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_trigger_level(o_trigger_level),
        .o_result_valid(o_result_valid),
        .o_echo_width_us(o_echo_width_us),
        .o_distance_hcm(o_distance_hcm),
        .o_percent_hundredths(o_percent_hundredths),
        .o_level_band(o_level_band),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ranging model state and register copies
    logic [HEIGHT_W-1:0]  m_height  = RST_TANK_HEIGHT;
    logic [SETTLE_W-1:0]  m_settle  = RST_SETTLE_LOW;
    logic [TRIG_W-1:0]    m_trig_w  = RST_TRIG_WIDTH;
    logic [HOLDOFF_W-1:0] m_holdoff = RST_HOLDOFF;
    t_phase               m_phase   = PH_SETTLE;
    int unsigned          m_ticks   = 0;
    int unsigned          m_echo    = 0;

    logic      echo_q[$];
    t_tick_exp tick_exp_q[$];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          n_errors      = 0;
    int          hold_req      = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;
    t_tick_exp   got_exp;

    function automatic t_tick_exp ranging_step(input logic echo);
        t_tick_exp   r;
        int unsigned tw;
        longint      h, d, p, pq;
        r = '0;
        r.band = BAND_NONE;
        tw = (m_trig_w == 0) ? 1 : m_trig_w;
        if (m_phase == PH_HOLDOFF && m_ticks >= m_holdoff) begin
            m_phase = PH_SETTLE;
            m_ticks = 0;
        end
        if (m_phase == PH_SETTLE && m_ticks >= m_settle) begin
            m_phase = PH_PULSE;
            m_ticks = 0;
        end
        case (m_phase)
            PH_SETTLE: m_ticks++;
            PH_PULSE: begin
                r.trig = 1'b1;
                m_ticks++;
                if (m_ticks >= tw) begin
                    m_phase = PH_WAIT;
                    m_ticks = 0;
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    m_phase = PH_MEASURE;
                    m_echo = 1;
                end
            end
            PH_MEASURE: begin
                if (echo) begin
                    if (m_echo < ECHO_SAT) m_echo++;
                end else begin
                    h = (m_height == 0) ? 1 : longint'(m_height);
                    d = (longint'(m_echo) * DIST_MUL) / DIST_DIV;
                    p = 100 * h - d;
                    pq = (p * PCT_SCALE) / h;
                    if (pq < longint'(PCT_FLOOR)) pq = longint'(PCT_FLOOR);
                    if (p > 23 * h && p < 27 * h) r.band = BAND_QUARTER;
                    else if (p > 48 * h && p < 52 * h) r.band = BAND_HALF;
                    else if (p > 73 * h && p < 77 * h) r.band = BAND_THREE_Q;
                    else if (p > 97 * h) r.band = BAND_FULL;
                    else if (p >= 0 && p < 5 * h) r.band = BAND_URGENT;
                    else if (p < 0) r.band = BAND_ERROR;
                    r.done     = 1'b1;
                    r.width    = m_echo[WIDTH_OUT_W-1:0];
                    r.dist_hcm = d[DIST_OUT_W-1:0];
                    r.pct      = pq[PCT_OUT_W-1:0];
                    m_phase = PH_HOLDOFF;
                    m_ticks = 0;
                    m_echo  = 0;
                end
            end
            default: m_ticks++;
        endcase
        return r;
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                tick_exp_q.push_back(ranging_step(i_echo_level));
                void'(echo_q.pop_front());
            end
            if (!i_in_valid || o_in_ready) begin
                if (echo_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid   <= 1'b1;
                    i_echo_level <= echo_q[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic cmp_field(input string what, input longint want, input longint got);
        if (want != got) begin
            n_errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // receiver and checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (tick_exp_q.size() == 0) begin
                n_errors++;
                $display("%0t: result with nothing expected: expected none, actual band %0d",
                    $time, o_level_band);
            end else begin
                got_exp = tick_exp_q.pop_front();
                cmp_field("trigger_level", got_exp.trig, o_trigger_level);
                cmp_field("result_valid", got_exp.done, o_result_valid);
                cmp_field("echo_width_us", got_exp.width, o_echo_width_us);
                cmp_field("distance_hcm", got_exp.dist_hcm, o_distance_hcm);
                cmp_field("percent_hundredths", $signed(got_exp.pct),
                    o_percent_hundredths);
                cmp_field("level_band", got_exp.band, o_level_band);
            end
        end
        if (hold_seen != hold_req) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_TANK_HEIGHT: m_height  = val[HEIGHT_W-1:0];
            REG_SETTLE_LOW:  m_settle  = val[SETTLE_W-1:0];
            REG_TRIG_WIDTH:  m_trig_w  = val[TRIG_W-1:0];
            REG_HOLDOFF:     m_holdoff = val[HOLDOFF_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // junk fills the bits above each register's width
    task automatic write_setup(input int unsigned h, input int unsigned s, input int unsigned t,
            input int unsigned hold, input bit junk);
        logic [CFG_DATA_W-1:0] up;
        logic [31:0]           hv, sv, tv, ov;
        up = CFG_DATA_W'($urandom);
        if (!junk) up = '0;
        hv = h;
        sv = s;
        tv = t;
        ov = hold;
        cfg_write(REG_TANK_HEIGHT, {up[CFG_DATA_W-1:HEIGHT_W], hv[HEIGHT_W-1:0]});
        cfg_write(REG_SETTLE_LOW, {up[CFG_DATA_W-1:SETTLE_W], sv[SETTLE_W-1:0]});
        cfg_write(REG_TRIG_WIDTH, {up[CFG_DATA_W-1:TRIG_W], tv[TRIG_W-1:0]});
        cfg_write(REG_HOLDOFF, ov[HOLDOFF_W-1:0]);
        if (junk) cfg_write(CFG_IDX_W'($urandom_range(4, 255)), up);
    endtask

    task automatic wait_idle();
        while (echo_q.size() != 0 || i_in_valid || tick_exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one ranging cycle aligned to the current setup; echo is don't-care outside wait/measure
    function automatic void push_ranging(input int unsigned echo_len, input int unsigned tail);
        int unsigned lead;
        lead = m_settle + ((m_trig_w == 0) ? 1 : m_trig_w);
        repeat (lead) echo_q.push_back(1'($urandom));
        repeat ($urandom_range(3)) echo_q.push_back(1'b0);
        repeat (echo_len) echo_q.push_back(1'b1);
        echo_q.push_back(1'b0);
        repeat (tail) echo_q.push_back(1'($urandom));
    endfunction

    task automatic random_run(input int unsigned n_items);
        int unsigned base, lim, h;
        repeat (3) begin
            wait_idle();
            case ($urandom_range(9))
                0:       h = $urandom_range(31, 1023);
                1, 2:    h = $urandom_range(0, 30);
                default: h = $urandom_range(1, 4);
            endcase
            write_setup(h, $urandom_range(4), $urandom_range(6), $urandom_range(10),
                1'($urandom_range(1)));
            lim = (m_height == 0) ? 130 : 130 * m_height;
            if (lim > 130) lim = 130;
            base = echo_q.size();
            while (echo_q.size() - base < n_items / 3) begin
                if ($urandom_range(99) < 15)
                    repeat ($urandom_range(1, 20)) echo_q.push_back(1'($urandom));
                else if ($urandom_range(1))
                    push_ranging($urandom_range(1, 8), m_holdoff);
                else
                    push_ranging($urandom_range(1, lim), m_holdoff);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 22;
        recv_idle_pct = 86;
        // reset setup: echo high during the pulse is ignored
        repeat (2) echo_q.push_back(1'b0);
        repeat (10) echo_q.push_back(1'b1);
        echo_q.push_back(1'b0);
        echo_q.push_back(1'b1);
        echo_q.push_back(1'b0);
        wait_idle();
        // zero height, settle, trigger width and holdoff
        write_setup(0, 0, 0, 0, 1'b0);
        echo_q.push_back(1'b0);
        repeat (3) echo_q.push_back(1'b1);
        echo_q.push_back(1'b0);
        echo_q.push_back(1'b1);
        echo_q.push_back(1'b1);
        echo_q.push_back(1'b0);
        hold_req++;
        random_run(30);

        send_idle_pct = 86;
        recv_idle_pct = 22;
        wait_idle();
        write_setup(1023, 255, 255, 20'hFFFFF, 1'b0);
        push_ranging(3, 5);
        random_run(30);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_run(30);

        wait_idle();
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
